@@ design/lom_pkg.sv @@
// Shared types for the limit order matcher: book entry payload and cell controls.
// Used by lom_cell, lom_book and limit_order_matcher_top.
package lom_pkg;

	localparam int PRICE_W = 16;
	localparam int QTY_W   = 32;
	localparam int ID_W    = 32;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FILL   = 2'd0;
	localparam kind_t KIND_END    = 2'd1;
	localparam kind_t KIND_REJECT = 2'd2;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
		logic [ID_W-1:0]    id;
	} ent_t;

	// one control word for a whole book row
	typedef struct packed {
		logic             insert;
		logic             pop;
		logic             wr_head;
		logic [QTY_W-1:0] wr_qty;
	} ctl_t;

endpackage

@@ design/lom_cell.sv @@
// One slot of a sorted order book row; swaps contents with its neighbours.
// Depends on lom_pkg.
module lom_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          is_ask,
	input  logic          is_head,
	input  lom_pkg::ctl_t ctl,
	input  lom_pkg::ent_t new_ent,
	input  logic          prev_take,
	input  lom_pkg::ent_t prev_ent,
	input  logic          prev_valid,
	input  lom_pkg::ent_t next_ent,
	input  logic          next_valid,
	output lom_pkg::ent_t ent,
	output logic          valid,
	output logic          take
);
	import lom_pkg::*;

	ent_t ent_q;
	logic valid_q;

	// empty slot or strictly worse price: new order lands at or before here
	assign take  = !valid_q || (is_ask ? (ent_q.price > new_ent.price)
	                                   : (ent_q.price < new_ent.price));
	assign ent   = ent_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (prev_take && !is_head) begin
				valid_q <= prev_valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_take && !is_head) begin
				ent_q <= prev_ent;
			end else if (take) begin
				ent_q <= new_ent;
			end
		end else if (ctl.pop) begin
			ent_q <= next_ent;
		end else if (ctl.wr_head && is_head) begin
			ent_q.qty <= ctl.wr_qty;
		end
	end

endmodule

@@ design/lom_book.sv @@
// One side of the book: a row of lom_cell slots kept in priority order.
// Depends on lom_pkg and lom_cell.
module lom_book #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          is_ask,
	input  lom_pkg::ctl_t ctl,
	input  lom_pkg::ent_t new_ent,
	output lom_pkg::ent_t head_ent,
	output logic          head_valid,
	output logic          full
);
	import lom_pkg::*;

	ent_t             ents  [BOOK_DEPTH];
	logic [BOOK_DEPTH-1:0] vals;
	logic [BOOK_DEPTH-1:0] takes;

	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
		lom_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.is_ask     (is_ask),
			.is_head    (i == 0),
			.ctl        (ctl),
			.new_ent    (new_ent),
			.prev_take  ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i-1]),
			.prev_ent   (ents[(i == 0) ? 0 : i-1]),
			.prev_valid (vals[(i == 0) ? 0 : i-1]),
			.next_ent   (ents[(i == BOOK_DEPTH-1) ? i : i+1]),
			.next_valid ((i == BOOK_DEPTH-1) ? 1'b0 : vals[(i == BOOK_DEPTH-1) ? i : i+1]),
			.ent        (ents[i]),
			.valid      (vals[i]),
			.take       (takes[i])
		);
	end

	assign head_ent   = ents[0];
	assign head_valid = vals[0];
	assign full       = vals[BOOK_DEPTH-1];

endmodule

@@ design/limit_order_matcher_top.sv @@
// Limit order matcher top level: handshakes, match sequencer, two book rows.
// Depends on lom_pkg, lom_book and lom_cell.
//
//  channel | dir | fields
//  --------+-----+-----------------------------------------------------------
//  s_*     | in  | one new limit order per word (side in tuser)
//  m_*     | out | fill / end / reject reports, tlast on the end report
//
// Sequence: the order is inserted on acceptance (or rejected if its side is full),
// then each match steps through compare, subtract, buy report and sell report,
// set by the sequencer and the single output register, before the end report.
// Reset clears the valid bit of every book slot, so both books start empty.
// A stalled m_tready holds the sequencer; s_tready is high only between items.
module limit_order_matcher_top #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // order_price[15:0], order_quantity[47:16], order_id[79:48]
	input  logic [0:0]   s_tuser,   // order_side[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // report_id[31:0], report_side[32], traded_quantity[64:33],
	                                // remaining_quantity[96:65], fill_status[97], zero pad
	output logic [1:0]   m_tuser,   // report_kind[1:0]
	output logic         m_tlast    // last_report
);
	import lom_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CMP, ST_SUB, ST_BID, ST_ASK, ST_END, ST_REJ
	} state_t;

	state_t state_q;

	// latched order
	logic             side_q;
	ent_t             ord_q;
	logic [QTY_W-1:0] own_left_q;
	logic             own_gone_q;

	// match working values
	logic [QTY_W-1:0] t_q, bq_q, aq_q;
	logic [ID_W-1:0]  bid_id_q, ask_id_q;

	// output register
	logic             out_v_q;
	kind_t            out_kind_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_side_q;
	logic [QTY_W-1:0] out_trd_q, out_rem_q;
	logic             out_fill_q, out_last_q;

	ent_t  in_ent, bid_head, ask_head;
	logic  bid_hv, ask_hv, bid_full, ask_full;
	ctl_t  bid_ctl, ask_ctl;
	logic  s_acc, in_side, free, emit_st;

	assign in_ent  = '{price: s_tdata[15:0], qty: s_tdata[47:16], id: s_tdata[79:48]};
	assign in_side = s_tuser[0];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign free     = !out_v_q || m_tready;
	// states that load a report word into the output register
	assign emit_st  = (state_q == ST_BID) || (state_q == ST_ASK) ||
	                  (state_q == ST_REJ) || (state_q == ST_END);

	// books: insert on acceptance, settle heads when the sell report is loaded
	always_comb begin
		bid_ctl = '{insert: 1'b0, pop: 1'b0, wr_head: 1'b0, wr_qty: bq_q};
		ask_ctl = '{insert: 1'b0, pop: 1'b0, wr_head: 1'b0, wr_qty: aq_q};
		if (s_acc) begin
			bid_ctl.insert = !in_side && !bid_full;
			ask_ctl.insert = in_side && !ask_full;
		end
		if (state_q == ST_ASK && free) begin
			bid_ctl.pop     = (bq_q == '0);
			bid_ctl.wr_head = (bq_q != '0);
			ask_ctl.pop     = (aq_q == '0);
			ask_ctl.wr_head = (aq_q != '0);
		end
	end

	lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
		.clk(clk), .arst_n(arst_n), .is_ask(1'b0), .ctl(bid_ctl), .new_ent(in_ent),
		.head_ent(bid_head), .head_valid(bid_hv), .full(bid_full)
	);

	lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
		.clk(clk), .arst_n(arst_n), .is_ask(1'b1), .ctl(ask_ctl), .new_ent(in_ent),
		.head_ent(ask_head), .head_valid(ask_hv), .full(ask_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready && !emit_st) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= (in_side ? ask_full : bid_full) ? ST_REJ : ST_CMP;
					end
				end
				ST_CMP: begin
					// crossing test on the two head cells
					if (bid_hv && ask_hv && (bid_head.price >= ask_head.price)) begin
						state_q <= ST_SUB;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_SUB:  state_q <= ST_BID;
				ST_BID: begin
					if (free) begin
						out_v_q <= 1'b1;
						state_q <= ST_ASK;
					end
				end
				ST_ASK: begin
					if (free) begin
						out_v_q <= 1'b1;
						state_q <= ST_CMP;
					end
				end
				ST_REJ: begin
					if (free) begin
						out_v_q <= 1'b1;
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (free) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload side, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					side_q     <= in_side;
					ord_q      <= in_ent;
					own_left_q <= in_ent.qty;
					own_gone_q <= 1'b0;
				end
			end
			ST_CMP: begin
				t_q      <= (bid_head.qty < ask_head.qty) ? bid_head.qty : ask_head.qty;
				bq_q     <= bid_head.qty;
				aq_q     <= ask_head.qty;
				bid_id_q <= bid_head.id;
				ask_id_q <= ask_head.id;
			end
			ST_SUB: begin
				bq_q <= bq_q - t_q;
				aq_q <= aq_q - t_q;
			end
			ST_BID: begin
				if (free) begin
					out_kind_q <= KIND_FILL;
					out_id_q   <= bid_id_q;
					out_side_q <= 1'b0;
					out_trd_q  <= t_q;
					out_rem_q  <= bq_q;
					out_fill_q <= (bq_q == '0);
					out_last_q <= 1'b0;
				end
			end
			ST_ASK: begin
				if (free) begin
					out_kind_q <= KIND_FILL;
					out_id_q   <= ask_id_q;
					out_side_q <= 1'b1;
					out_trd_q  <= t_q;
					out_rem_q  <= aq_q;
					out_fill_q <= (aq_q == '0);
					out_last_q <= 1'b0;
					// new order always sits at the head of its side once crossing
					own_left_q <= side_q ? aq_q : bq_q;
					own_gone_q <= side_q ? (aq_q == '0) : (bq_q == '0);
				end
			end
			ST_REJ: begin
				if (free) begin
					out_kind_q <= KIND_REJECT;
					out_id_q   <= ord_q.id;
					out_side_q <= side_q;
					out_trd_q  <= '0;
					out_rem_q  <= ord_q.qty;
					out_fill_q <= 1'b0;
					out_last_q <= 1'b0;
					own_left_q <= '0;
					own_gone_q <= 1'b0;
				end
			end
			ST_END: begin
				if (free) begin
					out_kind_q <= KIND_END;
					out_id_q   <= ord_q.id;
					out_side_q <= side_q;
					out_trd_q  <= '0;
					out_rem_q  <= own_left_q;
					out_fill_q <= own_gone_q;
					out_last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_fill_q, out_rem_q, out_trd_q, out_side_q, out_id_q};

endmodule

@@ bench/lom_checker.sv @@
// Order book scoreboard: models both price-time books, predicts the report words
// for every accepted order and compares them with the m_* channel. Needs lom_pkg.
module lom_checker #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [79:0]  s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	output int           pending,
	output int           fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import lom_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] id;
		logic        side;
		logic [31:0] traded;
		logic [31:0] remain;
		logic        filled;
		logic        last;
	} report_t;

	report_t reports_due[$];

	logic [15:0] bid_px[BOOK_DEPTH], ask_px[BOOK_DEPTH];
	logic [31:0] bid_qty[BOOK_DEPTH], ask_qty[BOOK_DEPTH];
	logic [31:0] bid_id[BOOK_DEPTH], ask_id[BOOK_DEPTH];
	int          n_bid, n_ask;

	function automatic report_t mk(kind_t k, logic [31:0] id, logic sd, logic [31:0] tr,
	                               logic [31:0] rm, logic st, logic ls);
		report_t r;
		r.kind = k; r.id = id; r.side = sd; r.traded = tr;
		r.remain = rm; r.filled = st; r.last = ls;
		return r;
	endfunction

	// insert behind every entry of equal or better price; shift the rest down
	task automatic book_order(logic sd, logic [15:0] p, logic [31:0] q, logic [31:0] id);
		int pos;
		int n;
		n = sd ? n_ask : n_bid;
		pos = n;
		for (int i = 0; i < n; i++) begin
			if (sd ? (ask_px[i] > p) : (bid_px[i] < p)) begin
				pos = i;
				break;
			end
		end
		for (int i = n; i > pos; i--) begin
			if (sd) begin
				ask_px[i] = ask_px[i-1]; ask_qty[i] = ask_qty[i-1]; ask_id[i] = ask_id[i-1];
			end else begin
				bid_px[i] = bid_px[i-1]; bid_qty[i] = bid_qty[i-1]; bid_id[i] = bid_id[i-1];
			end
		end
		if (sd) begin
			ask_px[pos] = p; ask_qty[pos] = q; ask_id[pos] = id; n_ask++;
		end else begin
			bid_px[pos] = p; bid_qty[pos] = q; bid_id[pos] = id; n_bid++;
		end
	endtask

	task automatic match_order(logic sd, logic [15:0] p, logic [31:0] q, logic [31:0] id);
		logic [31:0] own_left, t, bq, aq;
		logic        own_gone;
		int          rounds;
		own_left = q;
		own_gone = 1'b0;
		rounds = 0;
		if ((sd ? n_ask : n_bid) >= BOOK_DEPTH) begin
			reports_due.push_back(mk(KIND_REJECT, id, sd, 32'd0, q, 1'b0, 1'b0));
			reports_due.push_back(mk(KIND_END, id, sd, 32'd0, 32'd0, 1'b0, 1'b1));
			return;
		end
		book_order(sd, p, q, id);
		while (n_bid > 0 && n_ask > 0 && bid_px[0] >= ask_px[0] && rounds < 2 * BOOK_DEPTH) begin
			t = (bid_qty[0] < ask_qty[0]) ? bid_qty[0] : ask_qty[0];
			bq = bid_qty[0] - t;
			aq = ask_qty[0] - t;
			rounds++;
			bid_qty[0] = bq;
			ask_qty[0] = aq;
			own_left = sd ? aq : bq;
			own_gone = (own_left == 0);
			reports_due.push_back(mk(KIND_FILL, bid_id[0], 1'b0, t, bq, bq == 0, 1'b0));
			reports_due.push_back(mk(KIND_FILL, ask_id[0], 1'b1, t, aq, aq == 0, 1'b0));
			if (bq == 0) begin
				for (int i = 0; i + 1 < n_bid; i++) begin
					bid_px[i] = bid_px[i+1]; bid_qty[i] = bid_qty[i+1]; bid_id[i] = bid_id[i+1];
				end
				n_bid--;
			end
			if (aq == 0) begin
				for (int i = 0; i + 1 < n_ask; i++) begin
					ask_px[i] = ask_px[i+1]; ask_qty[i] = ask_qty[i+1]; ask_id[i] = ask_id[i+1];
				end
				n_ask--;
			end
		end
		reports_due.push_back(mk(KIND_END, id, sd, 32'd0, own_left, own_gone, 1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t got, want;
		if (!arst_n) begin
			n_bid = 0;
			n_ask = 0;
			reports_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				match_order(s_tuser[0], s_tdata[15:0], s_tdata[47:16], s_tdata[79:48]);
			if (m_tvalid && m_tready) begin
				got = mk(m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[64:33], m_tdata[96:65],
				         m_tdata[97], m_tlast);
				if (reports_due.size() == 0) begin
					if (fails < 10)
						$display("unexpected report word: %p", got);
					fails++;
				end else begin
					want = reports_due.pop_front();
					if (got.kind !== want.kind || got.id !== want.id || got.side !== want.side
					    || got.traded !== want.traded || got.remain !== want.remain
					    || got.filled !== want.filled || got.last !== want.last) begin
						if (fails < 10)
							$display("report mismatch: expected %p, got %p", want, got);
						fails++;
					end
				end
			end
			pending = reports_due.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// Stimulus and verdict for limit_order_matcher_top; checking lives in lom_checker.
// Needs lom_pkg, the matcher RTL and bench/lom_checker.sv.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [79:0]  s_tdata = '0;   // order_price[15:0], order_quantity[47:16], order_id[79:48]
	logic [0:0]   s_tuser = '0;   // order_side[0]
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [103:0] m_tdata;        // report_id, report_side, traded, remaining, fill_status
	logic [1:0]   m_tuser;        // report_kind[1:0]
	logic         m_tlast;

	int pending, fails;
	bit calm = 0;      // set for the closing stretch: no gaps, no stalls
	int stall_left = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	limit_order_matcher_top #(.BOOK_DEPTH(DEPTH)) i_dut (.*);

	lom_checker #(.BOOK_DEPTH(DEPTH)) i_checker (.*);

	// receiver: drops m_tready in random stall bursts
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one order word; valid is only dropped when a gap follows, so back-to-back
	// words never lower and raise s_tvalid in the same step
	task automatic send_order(logic sd, logic [15:0] p, logic [31:0] q, logic [31:0] id);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= sd;
		s_tdata <= {id, q, p};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random();
		int pick;
		logic [15:0] p;
		logic [31:0] q;
		pick = $urandom_range(0, 99);
		// mostly a tight band round the mid so orders cross and books churn
		p = 16'(1000 + $urandom_range(0, 40) - 20);
		q = $urandom_range(1, 60);
		if (pick < 8) begin
			p = 16'($urandom);
			q = $urandom;
		end else if (pick < 12) begin
			q = 0;
		end else if (pick < 20) begin
			// far from the mid: builds depth and eventually a full side
			p = 16'($urandom_range(0, 1) ? $urandom_range(0, 200)
			                             : $urandom_range(5000, 65535));
		end
		send_order(1'($urandom_range(0, 1)), p, q, $urandom);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial fill, exact fill, zero quantity resting then crossed, extremes
		send_order(1'b0, 16'd100, 32'd10, 32'd1);
		send_order(1'b1, 16'd100, 32'd4, 32'd2);
		send_order(1'b1, 16'd90, 32'd6, 32'd3);
		send_order(1'b1, 16'd0, 32'd0, 32'd4);
		send_order(1'b0, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_order(1'b1, 16'hFFFF, 32'd1, 32'd0);
		send_order(1'b1, 16'd0, 32'hFFFFFFFF, 32'd5);
		send_order(1'b0, 16'd0, 32'd1, 32'd6);
		send_order(1'b0, 16'd50, 32'd0, 32'd7);      // zero quantity resting on the bid
		send_order(1'b1, 16'd40, 32'd3, 32'd8);      // crosses the zero bid, 0 traded
		// fill the bid side, duplicate prices for time priority, then overflow
		for (int i = 0; i < DEPTH; i++)
			send_order(1'b0, 16'(10 + i % 5), 32'(2 + i), 32'(100 + i));
		send_order(1'b0, 16'd20, 32'd9, 32'd200);    // side full: rejected
		send_order(1'b1, 16'd0, 32'hFFFFFFFF, 32'd201);  // sweeps all sixteen bids
		send_order(1'b0, 16'd0, 32'hFFFFFFFF, 32'd202);  // takes the rest of the sweeping ask

		for (int n = 0; n < 380; n++) begin
			if (n == 150) begin
				// hold off until the book has reported everything so far
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			if (n == 330)
				calm = 1'b1;
			send_random();
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (30) @(posedge clk);
		if (fails == 0)
			$display("[limit_order_matcher_top] OK");
		else
			$display("[limit_order_matcher_top] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("[limit_order_matcher_top] ERROR");
		$finish;
	end

endmodule
